// ===== rtl/cfr_pkg.sv =====
// shared types, codes and constants of the command frame recogniser
// used by the channel interfaces and the top level; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

	// size of the type table and how much of it is searched
	localparam int NUM_TYPES     = 4;
	localparam int NUM_TYPE_REGS = 4;
	localparam int NUM_SEARCH    = (NUM_TYPES < NUM_TYPE_REGS) ? NUM_TYPES : NUM_TYPE_REGS;

	localparam int BYTE_W      = 8;
	localparam int SLOT_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int TAIL_W      = 24;

	typedef logic [BYTE_W-1:0]      byte_t;
	typedef logic [SLOT_W-1:0]      slot_t;
	typedef logic [STATUS_W-1:0]    status_t;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [TAIL_W-1:0]      tail_t;

	// frame status codes
	localparam status_t ST_COLLECTING = 2'd0;
	localparam status_t ST_INVALID    = 2'd1;
	localparam status_t ST_ASSEMBLED  = 2'd2;

	// configuration register indexes
	localparam cfg_index_t REG_TYPE_CODE_0 = 3'd0;
	localparam cfg_index_t REG_SPACER      = 3'd4;
	localparam cfg_index_t REG_CAPACITY    = 3'd5;

	// framing constants
	localparam byte_t MIN_FRAME      = 8'd6;
	localparam byte_t TERM_FIRST     = 8'h0A;
	localparam byte_t SPACER_RESET   = 8'h5F;
	localparam byte_t CAPACITY_RESET = 8'hFF;
	localparam tail_t TERM_TAIL      = {TERM_FIRST, 16'h0000};

	typedef struct packed {
		status_t frame_status;
		byte_t   echo_byte;
		byte_t   byte_position;
		slot_t   type_slot;
		byte_t   payload_length;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/cfr_in_if.sv =====
// byte input channel of the command frame recogniser
// depends on cfr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface cfr_in_if;
	logic          valid;
	logic          ready;
	cfr_pkg::byte_t data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfr_out_if.sv =====
// result channel of the command frame recogniser
// depends on cfr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface cfr_out_if;
	logic             valid;
	logic             ready;
	cfr_pkg::status_t frame_status;
	cfr_pkg::byte_t   echo_byte;
	cfr_pkg::byte_t   byte_position;
	cfr_pkg::slot_t   type_slot;
	cfr_pkg::byte_t   payload_length;

	modport source (output valid, output frame_status, output echo_byte,
		output byte_position, output type_slot, output payload_length, input ready);
	modport sink (input valid, input frame_status, input echo_byte,
		input byte_position, input type_slot, input payload_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/command_frame_recognizer.sv =====
// top level of the command frame recogniser: input register, framing logic, result register
// depends on cfr_pkg, cfr_in_if and cfr_out_if
`timescale 1ns / 1ps
`default_nettype none

// usage
// - stream: one byte of the command stream per transaction (valid/ready)
// - result: one transaction per input byte with status, echoed byte, position in the
//   frame, matched type slot and payload length (non-zero only when assembled)
// - configuration: cfg_we/cfg_index/cfg_data write port, registers 0..3 type codes,
//   4 spacer byte, 5 capacity; indexes above 5 are ignored; write only while idle
// timing: a byte accepted into the input register is framed combinationally there; its
//   result is written to the result register when the byte advances, which an untaken
//   result can delay, and result valid is driven directly from the result register
// throughput: one byte per cycle while results are taken; the framing state is updated in the same cycle
//   that a byte leaves the input register, so consecutive bytes follow with no gap
// stall: while the result register holds an untaken result, the byte in the input
//   register waits; stream ready follows result ready combinationally, so up to two
//   bytes are held in the block and nothing is dropped
// reset: arst_n clears the frame state, both valid flags, type codes (to zero),
//   spacer (to 0x5F) and capacity (to 255); no clearing pass is needed
module command_frame_recognizer (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  cfr_pkg::cfg_index_t cfg_index,
	input  cfr_pkg::byte_t      cfg_data,
	cfr_in_if.sink              stream,
	cfr_out_if.source           result
);

	// configuration registers
	cfr_pkg::byte_t type_code_q [cfr_pkg::NUM_TYPE_REGS];
	cfr_pkg::byte_t spacer_q;
	cfr_pkg::byte_t capacity_q;

	// frame state
	cfr_pkg::byte_t frame_length_q;
	cfr_pkg::slot_t matched_slot_q;
	logic           slot_valid_q;
	cfr_pkg::tail_t tail_q;

	// input register
	logic           valid_s1;
	cfr_pkg::byte_t data_s1;

	// result register
	logic             res_valid_q;
	cfr_pkg::result_t res_q;

	logic advance;

	// framing signals
	logic             full;
	cfr_pkg::byte_t   len_base;
	logic             slot_valid_base;
	cfr_pkg::slot_t   slot_base;
	cfr_pkg::tail_t   tail_base;
	cfr_pkg::byte_t   len;
	logic             hit;
	logic             stop;
	cfr_pkg::slot_t   hit_slot;
	logic             slot_valid_nxt;
	cfr_pkg::slot_t   slot_nxt;
	logic             room_short;
	cfr_pkg::byte_t   room;
	cfr_pkg::status_t status_c;
	cfr_pkg::byte_t   payload_c;

	// the byte moves on when the result register is free or being emptied
	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign stream.ready = !valid_s1 || advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cfr_pkg::NUM_TYPE_REGS; i++) begin
				type_code_q[i] <= '0;
			end
			spacer_q   <= cfr_pkg::SPACER_RESET;
			capacity_q <= cfr_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			if (cfg_index < cfr_pkg::REG_SPACER) begin
				type_code_q[cfg_index[1:0]] <= cfg_data;
			end else if (cfg_index == cfr_pkg::REG_SPACER) begin
				spacer_q <= cfg_data;
			end else if (cfg_index == cfr_pkg::REG_CAPACITY) begin
				capacity_q <= cfg_data;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_s1 <= stream.data_byte;
		end
	end

	// framing logic for the byte in the input register
	always_comb begin
		// a full buffer silently starts a new frame
		full            = frame_length_q >= capacity_q;
		len_base        = full ? '0 : frame_length_q;
		slot_valid_base = full ? 1'b0 : slot_valid_q;
		slot_base       = full ? '0 : matched_slot_q;
		tail_base       = full ? '0 : tail_q;
		len             = len_base + 8'd1;

		// type lookup, table ends at the first zero entry
		hit      = 1'b0;
		stop     = 1'b0;
		hit_slot = '0;
		for (int i = 0; i < cfr_pkg::NUM_SEARCH; i++) begin
			if (!stop) begin
				if (type_code_q[i] == 8'd0) begin
					stop = 1'b1;
				end else if (type_code_q[i] == data_s1) begin
					hit      = 1'b1;
					hit_slot = cfr_pkg::SLOT_W'(i);
					stop     = 1'b1;
				end
			end
		end

		status_c       = cfr_pkg::ST_COLLECTING;
		payload_c      = '0;
		slot_valid_nxt = slot_valid_base;
		slot_nxt       = slot_base;
		if (!slot_valid_base) begin
			if (hit) begin
				slot_valid_nxt = 1'b1;
				slot_nxt       = hit_slot;
			end else begin
				status_c = cfr_pkg::ST_INVALID;
			end
		end

		// room left after this byte; the subtraction wraps when capacity is below the length
		room       = capacity_q - len;
		room_short = (capacity_q < len) || (room < cfr_pkg::MIN_FRAME);

		if (status_c == cfr_pkg::ST_COLLECTING && len >= 8'd2) begin
			if (len == 8'd2 && data_s1 != spacer_q) begin
				status_c = cfr_pkg::ST_INVALID;
			end else if (room_short) begin
				status_c = cfr_pkg::ST_INVALID;
			end else if (len >= cfr_pkg::MIN_FRAME && data_s1 == 8'd0 &&
				tail_base == cfr_pkg::TERM_TAIL) begin
				status_c  = cfr_pkg::ST_ASSEMBLED;
				payload_c = len - cfr_pkg::MIN_FRAME;
			end
		end
	end

	// frame state, cleared after an invalid or assembled frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= '0;
			matched_slot_q <= '0;
			slot_valid_q   <= 1'b0;
			tail_q         <= '0;
		end else if (advance) begin
			if (status_c != cfr_pkg::ST_COLLECTING) begin
				frame_length_q <= '0;
				matched_slot_q <= '0;
				slot_valid_q   <= 1'b0;
				tail_q         <= '0;
			end else begin
				frame_length_q <= len;
				matched_slot_q <= slot_nxt;
				slot_valid_q   <= slot_valid_nxt;
				tail_q         <= {tail_base[cfr_pkg::TAIL_W-cfr_pkg::BYTE_W-1:0], data_s1};
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.frame_status   <= status_c;
			res_q.echo_byte      <= data_s1;
			res_q.byte_position  <= len_base;
			res_q.type_slot      <= slot_valid_nxt ? slot_nxt : '0;
			res_q.payload_length <= payload_c;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.frame_status   = res_q.frame_status;
	assign result.echo_byte      = res_q.echo_byte;
	assign result.byte_position  = res_q.byte_position;
	assign result.type_slot      = res_q.type_slot;
	assign result.payload_length = res_q.payload_length;

	// an assembled frame carries its payload length as position minus five
	a_payload_matches_position: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.frame_status == cfr_pkg::ST_ASSEMBLED) |->
		(result.payload_length == 8'(result.byte_position - 8'd5)))
		else $error("assembled payload length does not match byte position");

	// only assembled results carry a payload length
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.frame_status != cfr_pkg::ST_ASSEMBLED) |->
		(result.payload_length == 8'd0))
		else $error("payload length set on a result that is not assembled");

	// a rejected or completed frame leaves the state empty
	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && status_c != cfr_pkg::ST_COLLECTING) |=>
		(frame_length_q == 8'd0 && !slot_valid_q))
		else $error("frame state not cleared after end of frame");

	// a matched slot only exists inside an open frame
	a_slot_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		slot_valid_q |-> (frame_length_q != 8'd0))
		else $error("slot marked valid with an empty frame");

endmodule

`default_nettype wire
